/* src/ghi_pkg.sv */
// shared widths, fixed-point constants and scale table for the gyro heading integrator
// no dependencies; used by gyro_heading_integrator, which passes its widths to ghi_serial_mul and ghi_serial_div
package ghi_pkg;

  // field and datapath widths
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned ANGLE_W   = 27;
  localparam int unsigned RANGE_W   = 2;
  localparam int unsigned SPU_W     = 8;
  localparam int unsigned SCALE_W   = 15;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned MAG_W     = 30;
  localparam int unsigned MUL_A_W   = SUM_W;
  localparam int unsigned MUL_B_W   = 16;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DEN_W     = 10;
  localparam int unsigned QUO_W     = 46;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 32;

  // rates and angles in units of 2^-24
  localparam int DEADBAND_Q = 503317;
  localparam int PI_Q       = 52707179;
  localparam int TWO_PI_Q   = 105414357;
  localparam int MS_PER_S   = 1000;
  localparam int SPU_RESET  = 10;

  // round(0.0174533 / sensitivity * 2^24) for each full-scale range
  localparam logic [SCALE_W-1:0] SCALE_K [4] = '{
    15'd2235, 15'd4471, 15'd8927, 15'd17855
  };

endpackage

/* src/ghi_serial_mul.sv */
// unsigned shift-add multiplier, one multiplier bit per cycle
// depends on nothing; parameters come from ghi_pkg through the top level
module ghi_serial_mul #(
  parameter int unsigned A_W = 40,
  parameter int unsigned B_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [A_W-1:0]     a_q;
  logic [A_W+B_W-1:0] p_q;
  logic [A_W:0]       part;
  logic [A_W+B_W-1:0] p_step;

  // add into the upper half, shift the whole product right
  assign part   = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
  assign p_step = {part, p_q[B_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_step;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

/* src/ghi_serial_div.sv */
// restoring divider, one quotient bit per cycle, quotient truncated
// depends on nothing; parameters come from ghi_pkg through the top level
module ghi_serial_div #(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // remainder stays below the divisor, so the trial needs one extra bit only
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* src/gyro_heading_integrator.sv */
// gyro heading integrator: scales z-rate samples, sums them past a deadband,
// integrates the batch average into a wrapped heading; uses ghi_pkg, ghi_serial_mul
// and ghi_serial_div
//
// the input stream carries one gyro sample per transaction: raw rate and elapsed
// milliseconds in tdata, tlast marking the final sample of a batch. every sample
// is scaled by the bit-serial multiplier, and tready stays low from each acceptance
// until that product has been summed, so no sample is taken while one is in work.
// a sample marked last then runs the batch update: divide by samples_per_update
// on the serial divider, multiply by elapsed_ms, divide by 1000, then add, wrap
// and clamp the heading; the heading appears once the final step finds the output
// register free, with tready back at the same time. the throughput is set by these
// serial multiplier and divider passes, one bit per cycle each. the output sits
// in a register: the next sample is taken while a heading waits for the receiver,
// and a stalled receiver only holds the block at the end of the following batch
// update. reset clears the sum and heading to zero and the registers to range 0
// and ten samples per update. configuration is written through cfg_we_i, while
// idle: the user must keep to that, as the block itself does not enforce it.
module gyro_heading_integrator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg_idx_i: 0 gyro_range, 1 samples_per_update
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [ghi_pkg::SPU_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] raw_rate, [31:16] elapsed_ms
  input  logic [ghi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // last_sample
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [26:0] angle, [31:27] zero
  output logic [ghi_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned RAW_W   = ghi_pkg::RAW_W;
  localparam int unsigned EL_W    = ghi_pkg::ELAPSED_W;
  localparam int unsigned ANG_W   = ghi_pkg::ANGLE_W;
  localparam int unsigned SUM_W   = ghi_pkg::SUM_W;
  localparam int unsigned MAG_W   = ghi_pkg::MAG_W;
  localparam int unsigned PROD_W  = ghi_pkg::PROD_W;
  localparam int unsigned A_W     = ghi_pkg::MUL_A_W;
  localparam int unsigned DEN_W   = ghi_pkg::DEN_W;
  localparam int unsigned QUO_W   = ghi_pkg::QUO_W;
  localparam int unsigned ACC_W   = ghi_pkg::ACC_W;

  localparam logic CfgGyroRange = 1'b0;
  localparam logic CfgSamples   = 1'b1;

  localparam logic signed [ACC_W-1:0] PiPos  = ACC_W'(ghi_pkg::PI_Q);
  localparam logic signed [ACC_W-1:0] PiNeg  = -ACC_W'(ghi_pkg::PI_Q);
  localparam logic signed [ACC_W-1:0] TwoPi  = ACC_W'(ghi_pkg::TWO_PI_Q);
  localparam logic signed [ANG_W-1:0] AngMax = ANG_W'(ghi_pkg::PI_Q);
  localparam logic signed [ANG_W-1:0] AngMin = -ANG_W'(ghi_pkg::PI_Q);
  localparam logic [MAG_W-1:0]        Deadband = MAG_W'(ghi_pkg::DEADBAND_Q);
  localparam logic [DEN_W-1:0]        MsDiv    = DEN_W'(ghi_pkg::MS_PER_S);
  localparam logic [SUM_W:0]          SumMax   = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W:0]          SumMin   = {2'b11, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_START_AVG,
    ST_DIV_AVG,
    ST_MUL_DT,
    ST_DIV_MS,
    ST_WRAP,
    ST_FINISH
  } state_e;

  state_e                         state_q;
  logic [ghi_pkg::RANGE_W-1:0]    range_q;
  logic [ghi_pkg::SPU_W-1:0]      spu_q;
  logic                           raw_neg_q;
  logic                           last_q;
  logic [EL_W-1:0]                elapsed_q;
  logic [SUM_W-1:0]               sum_q;
  logic signed [ANG_W-1:0]        angle_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic                           m_valid_q;
  logic [ANG_W-1:0]               m_data_q;

  logic                           s_accept;
  logic                           out_free;
  logic [RAW_W-1:0]               raw;
  logic [RAW_W-1:0]               raw_abs;
  logic [SUM_W-1:0]               sum_abs;
  logic [DEN_W-1:0]               spu_den;

  logic                           mul_start;
  logic [A_W-1:0]                 mul_a;
  logic [ghi_pkg::MUL_B_W-1:0]    mul_b;
  logic                           mul_done;
  logic [PROD_W-1:0]              mul_prod;

  logic                           div_start;
  logic [PROD_W-1:0]              div_num;
  logic [DEN_W-1:0]               div_den;
  logic                           div_done;
  logic [PROD_W-1:0]              div_quo;

  logic [MAG_W-1:0]               mag;
  logic                           keep;
  logic [SUM_W:0]                 rate_ext;
  logic [SUM_W:0]                 sum_add;
  logic [SUM_W-1:0]               sum_next;
  logic [ACC_W-1:0]               delta;
  logic signed [ACC_W-1:0]        acc_new;
  logic signed [ACC_W-1:0]        acc_wrap;
  logic signed [ACC_W-1:0]        acc_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign raw     = s_axis_tdata[RAW_W-1:0];
  assign raw_abs = raw[RAW_W-1] ? (~raw + RAW_W'(1)) : raw;
  assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign spu_den = (spu_q == '0) ? DEN_W'(1) : DEN_W'(spu_q);

  // the multiplier scales samples, then forms average times elapsed time
  assign mul_start = s_accept || ((state_q == ST_DIV_AVG) && div_done);
  assign mul_a     = (state_q == ST_IDLE) ? A_W'(ghi_pkg::SCALE_K[range_q]) : div_quo[A_W-1:0];
  assign mul_b     = (state_q == ST_IDLE) ? raw_abs : elapsed_q;

  // the divider takes the batch average, then the millisecond scaling
  assign div_start = (state_q == ST_START_AVG) || ((state_q == ST_MUL_DT) && mul_done);
  assign div_num   = (state_q == ST_START_AVG) ? PROD_W'(sum_abs) : mul_prod;
  assign div_den   = (state_q == ST_START_AVG) ? spu_den : MsDiv;

  // deadband and saturating accumulation on sign and magnitude
  assign mag      = mul_prod[MAG_W-1:0];
  assign keep     = mag >= Deadband;
  assign rate_ext = raw_neg_q ? -(SUM_W+1)'(mag) : (SUM_W+1)'(mag);
  assign sum_add  = {sum_q[SUM_W-1], sum_q} + rate_ext;
  always_comb begin
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_next = sum_add[SUM_W] ? SumMin[SUM_W-1:0] : SumMax[SUM_W-1:0];
    end else begin
      sum_next = sum_add[SUM_W-1:0];
    end
  end

  // the increment takes the sign of the sum
  assign delta   = sum_q[SUM_W-1] ? -ACC_W'(div_quo[QUO_W-1:0]) : ACC_W'(div_quo[QUO_W-1:0]);
  assign acc_new = ACC_W'(angle_q) + $signed(delta);

  always_comb begin
    if (acc_q > PiPos) begin
      acc_wrap = acc_q - TwoPi;
    end else if (acc_q < PiNeg) begin
      acc_wrap = acc_q + TwoPi;
    end else begin
      acc_wrap = acc_q;
    end
  end

  always_comb begin
    if (acc_q > PiPos) begin
      acc_sat = PiPos;
    end else if (acc_q < PiNeg) begin
      acc_sat = PiNeg;
    end else begin
      acc_sat = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      spu_q   <= ghi_pkg::SPU_W'(ghi_pkg::SPU_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGyroRange: range_q <= cfg_wdata_i[ghi_pkg::RANGE_W-1:0];
        CfgSamples:   spu_q   <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      raw_neg_q <= 1'b0;
      last_q    <= 1'b0;
      elapsed_q <= '0;
      sum_q     <= '0;
      angle_q   <= '0;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // the final step reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            raw_neg_q <= raw[RAW_W-1];
            last_q    <= s_axis_tlast;
            elapsed_q <= s_axis_tdata[RAW_W+EL_W-1:RAW_W];
            state_q   <= ST_MUL_RATE;
          end
        end
        ST_MUL_RATE: begin
          if (mul_done) begin
            if (keep) begin
              sum_q <= sum_next;
            end
            state_q <= last_q ? ST_START_AVG : ST_IDLE;
          end
        end
        ST_START_AVG: begin
          state_q <= ST_DIV_AVG;
        end
        ST_DIV_AVG: begin
          if (div_done) begin
            state_q <= ST_MUL_DT;
          end
        end
        ST_MUL_DT: begin
          if (mul_done) begin
            state_q <= ST_DIV_MS;
          end
        end
        ST_DIV_MS: begin
          if (div_done) begin
            acc_q   <= acc_new;
            state_q <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          acc_q   <= acc_wrap;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            angle_q   <= acc_sat[ANG_W-1:0];
            m_data_q  <= acc_sat[ANG_W-1:0];
            m_valid_q <= 1'b1;
            sum_q     <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(ghi_pkg::M_TDATA_W-ANG_W){1'b0}}, m_data_q};

  ghi_serial_mul #(
    .A_W (A_W),
    .B_W (ghi_pkg::MUL_B_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ghi_serial_div #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // heading never leaves the wrapped range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_q <= AngMax) && (angle_q >= AngMin))
    else $error("heading outside wrapped range");

  // a new heading is only raised by the final update step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("output raised outside final step");

  // the batch sum restarts once a heading has been issued
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && out_free |=> (sum_q == '0))
    else $error("sum not cleared after update");

  // serial units only finish in the states waiting on them
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_AVG) || (state_q == ST_DIV_MS))
    else $error("divider finished in an unexpected state");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_RATE) || (state_q == ST_MUL_DT))
    else $error("multiplier finished in an unexpected state");

endmodule
